// ===== sv/kscqp_pkg.sv =====
// Shared types, codes and functions of the key scan code queue pacer.
// Holds the character-to-scan-code table and the ring slot arithmetic.
// Depends on nothing; every other file but kscqp_ram imports it.
package kscqp_pkg;

    localparam int QUEUE_SLOTS = 16;
    localparam int SLOT_W      = $clog2(QUEUE_SLOTS);

    localparam int OPQ_DEPTH   = 2;
    localparam int OPQ_PTR_W   = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W   = $clog2(OPQ_DEPTH + 1);
    localparam int RESQ_DEPTH  = 2;
    localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W  = $clog2(RESQ_DEPTH + 1);

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [SLOT_W:0]   t_slot_wide;

    // input commands
    localparam logic [1:0] CMD_CHAR = 2'd0;
    localparam logic [1:0] CMD_RAW  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // classified operations between front and back
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_DROP = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    // key actions
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_PRESS   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ATTACHED = 2'd0;
    localparam logic [1:0] REG_HOLD     = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    localparam logic       RST_ATTACHED = 1'b1;
    localparam logic [3:0] RST_HOLD     = 4'd3;
    localparam logic [3:0] RST_GAP      = 4'd2;

    typedef struct packed {
        logic       attached;
        logic [3:0] hold;
        logic [3:0] gap;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] code;
    } t_op;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] code;
        logic       dropped;
        logic [3:0] count;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } t_map;

    function automatic t_slot next_slot(input t_slot s);
        if (s == t_slot'(QUEUE_SLOTS - 1)) begin
            return '0;
        end
        return s + t_slot'(1);
    endfunction

    function automatic logic [3:0] queue_count(input t_slot w, input t_slot r);
        t_slot_wide d;
        if (w >= r) begin
            d = {1'b0, w} - {1'b0, r};
        end else begin
            d = {1'b0, w} + t_slot_wide'(QUEUE_SLOTS) - {1'b0, r};
        end
        return 4'(d);
    endfunction

    // Delete maps as backspace; uppercase letters take the lowercase code plus shift.
    function automatic t_map map_char(input logic [7:0] ch);
        logic [7:0] c;
        logic [7:0] extra;
        t_map       m;
        c     = ch;
        extra = 8'h00;
        m.hit = 1'b1;
        if (c == 8'h7F) begin
            c = 8'h08;
        end
        if (c >= 8'h41 && c <= 8'h5A) begin
            c     = c + 8'h20;
            extra = 8'h40;
        end
        unique case (c)
            8'h6C: m.code = 8'h00;
            8'h6A: m.code = 8'h01;
            8'h3B: m.code = 8'h02;
            8'h6B: m.code = 8'h05;
            8'h2B: m.code = 8'h06;
            8'h2A: m.code = 8'h07;
            8'h6F: m.code = 8'h08;
            8'h70: m.code = 8'h0A;
            8'h75: m.code = 8'h0B;
            8'h0D: m.code = 8'h0C;
            8'h69: m.code = 8'h0D;
            8'h2D: m.code = 8'h0E;
            8'h3D: m.code = 8'h0F;
            8'h76: m.code = 8'h10;
            8'h63: m.code = 8'h12;
            8'h62: m.code = 8'h15;
            8'h78: m.code = 8'h16;
            8'h7A: m.code = 8'h17;
            8'h34: m.code = 8'h18;
            8'h33: m.code = 8'h1A;
            8'h36: m.code = 8'h1B;
            8'h1B: m.code = 8'h1C;
            8'h35: m.code = 8'h1D;
            8'h32: m.code = 8'h1E;
            8'h31: m.code = 8'h1F;
            8'h2C: m.code = 8'h20;
            8'h20: m.code = 8'h21;
            8'h2E: m.code = 8'h22;
            8'h6E: m.code = 8'h23;
            8'h6D: m.code = 8'h25;
            8'h2F: m.code = 8'h26;
            8'h72: m.code = 8'h28;
            8'h65: m.code = 8'h2A;
            8'h79: m.code = 8'h2B;
            8'h09: m.code = 8'h2C;
            8'h74: m.code = 8'h2D;
            8'h77: m.code = 8'h2E;
            8'h71: m.code = 8'h2F;
            8'h39: m.code = 8'h30;
            8'h30: m.code = 8'h32;
            8'h37: m.code = 8'h33;
            8'h08: m.code = 8'h34;
            8'h38: m.code = 8'h35;
            8'h3C: m.code = 8'h36;
            8'h3E: m.code = 8'h37;
            8'h66: m.code = 8'h38;
            8'h68: m.code = 8'h39;
            8'h64: m.code = 8'h3A;
            8'h67: m.code = 8'h3D;
            8'h73: m.code = 8'h3E;
            8'h61: m.code = 8'h3F;
            8'h21: m.code = 8'h5F;
            8'h22: m.code = 8'h5E;
            8'h23: m.code = 8'h5A;
            8'h24: m.code = 8'h58;
            8'h25: m.code = 8'h5D;
            8'h26: m.code = 8'h5B;
            8'h27: m.code = 8'h73;
            8'h40: m.code = 8'h75;
            8'h28: m.code = 8'h70;
            8'h29: m.code = 8'h72;
            8'h3A: m.code = 8'h42;
            8'h5C: m.code = 8'h46;
            8'h5E: m.code = 8'h47;
            8'h5F: m.code = 8'h4E;
            8'h7C: m.code = 8'h4F;
            8'h3F: m.code = 8'h66;
            8'h5B: m.code = 8'h60;
            8'h5D: m.code = 8'h62;
            default: begin
                m.hit  = 1'b0;
                m.code = 8'h00;
            end
        endcase
        m.code = m.code | extra;
        return m;
    endfunction

endpackage

// ===== sv/kscqp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module kscqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/kscqp_front.sv =====
// Front end: accepts input beats and classifies them into queue operations.
// Translates host characters through the table in kscqp_pkg.
module kscqp_front (
    input  logic              i_push,
    input  logic              i_opq_full,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_char_code,
    input  logic [7:0]        i_raw_code,
    input  kscqp_pkg::t_cfg   i_cfg,
    output logic              o_full,
    output logic              o_op_push,
    output kscqp_pkg::t_op    o_op
);
    import kscqp_pkg::*;

    t_map c_map;

    assign c_map     = map_char(i_char_code);
    assign o_full    = i_opq_full;
    assign o_op_push = i_push && !i_opq_full;

    always_comb begin
        o_op.code = i_raw_code;
        unique case (i_cmd)
            CMD_CHAR: begin
                o_op.code = c_map.code;
                o_op.kind = (i_cfg.attached && c_map.hit) ? OP_PUSH : OP_DROP;
            end
            CMD_RAW:  o_op.kind = i_cfg.attached ? OP_PUSH : OP_DROP;
            CMD_TICK: o_op.kind = OP_TICK;
            default:  o_op.kind = OP_NOP;
        endcase
    end
endmodule

// ===== sv/kscqp_opq.sv =====
// Short operation queue between front and back ends.
// Uses t_op and depth constants from kscqp_pkg.
module kscqp_opq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  kscqp_pkg::t_op  i_op,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output kscqp_pkg::t_op  o_op
);
    import kscqp_pkg::*;

    t_op                  r_mem [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0] r_wp, r_rp;
    logic [OPQ_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == OPQ_CNT_W'(OPQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + OPQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + OPQ_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + OPQ_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - OPQ_CNT_W'(1);
            end
        end
    end
endmodule

// ===== sv/kscqp_back.sv =====
// Back end: runs queue operations against the code ring and paces key presses.
// Depends on kscqp_pkg and one kscqp_ram instance for the code store.
module kscqp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kscqp_pkg::t_cfg     i_cfg,
    input  logic                i_op_valid,
    input  kscqp_pkg::t_op      i_op,
    output logic                o_op_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output kscqp_pkg::t_result  o_res
);
    import kscqp_pkg::*;

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic       r_state, n_state;
    t_slot      r_rd_slot, n_rd_slot;
    t_slot      r_wr_slot, n_wr_slot;
    logic [3:0] r_hold_left, n_hold_left;
    logic [3:0] r_gap_left, n_gap_left;

    logic       c_we, c_re;
    logic [7:0] c_rdata;
    t_slot      c_wr_next;

    kscqp_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_SLOTS)
    ) u_code_store (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_wr_slot),
        .i_wdata (i_op.code),
        .i_re    (c_re),
        .i_raddr (r_rd_slot),
        .o_rdata (c_rdata)
    );

    assign c_wr_next = next_slot(r_wr_slot);

    always_comb begin
        n_state        = r_state;
        n_rd_slot      = r_rd_slot;
        n_wr_slot      = r_wr_slot;
        n_hold_left    = r_hold_left;
        n_gap_left     = r_gap_left;
        c_we           = 1'b0;
        c_re           = 1'b0;
        o_op_pop       = 1'b0;
        o_res_push     = 1'b0;
        o_res.action   = ACT_NONE;
        o_res.code     = 8'h00;
        o_res.dropped  = 1'b0;
        if (r_state == ST_READ) begin
            // code read last cycle; the ring pointers already moved
            n_state      = ST_RUN;
            o_res_push   = 1'b1;
            o_res.action = ACT_PRESS;
            o_res.code   = c_rdata;
        end else if (i_op_valid && !i_res_full) begin
            o_op_pop   = 1'b1;
            o_res_push = 1'b1;
            unique case (i_op.kind)
                OP_PUSH: begin
                    if (c_wr_next == r_rd_slot) begin
                        o_res.dropped = 1'b1;
                    end else begin
                        c_we      = 1'b1;
                        n_wr_slot = c_wr_next;
                    end
                end
                OP_DROP: o_res.dropped = 1'b1;
                OP_TICK: begin
                    priority if (r_hold_left != 4'd0) begin
                        n_hold_left = r_hold_left - 4'd1;
                        if (r_hold_left == 4'd1) begin
                            o_res.action = ACT_RELEASE;
                            n_gap_left   = i_cfg.gap;
                        end
                    end else if (r_gap_left != 4'd0) begin
                        n_gap_left = r_gap_left - 4'd1;
                    end else if (r_rd_slot != r_wr_slot) begin
                        // hold the result until the code comes out of the store
                        o_res_push  = 1'b0;
                        c_re        = 1'b1;
                        n_rd_slot   = next_slot(r_rd_slot);
                        n_hold_left = (i_cfg.hold == 4'd0) ? 4'd1 : i_cfg.hold;
                        n_state     = ST_READ;
                    end else begin
                        n_hold_left = r_hold_left;
                    end
                end
                default: o_res.dropped = 1'b0;
            endcase
        end
        o_res.count = queue_count(n_wr_slot, n_rd_slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_rd_slot   <= '0;
            r_wr_slot   <= '0;
            r_hold_left <= 4'd0;
            r_gap_left  <= 4'd0;
        end else begin
            r_state     <= n_state;
            r_rd_slot   <= n_rd_slot;
            r_wr_slot   <= n_wr_slot;
            r_hold_left <= n_hold_left;
            r_gap_left  <= n_gap_left;
        end
    end
endmodule

// ===== sv/kscqp_resq.sv =====
// Result queue in front of the output ports; parts back end from the consumer.
// Uses t_result and depth constants from kscqp_pkg.
module kscqp_resq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  kscqp_pkg::t_result  i_res,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output kscqp_pkg::t_result  o_res
);
    import kscqp_pkg::*;

    t_result               r_mem [RESQ_DEPTH];
    logic [RESQ_PTR_W-1:0] r_wp, r_rp;
    logic [RESQ_CNT_W-1:0] r_cnt;
    logic                  c_pop;

    assign o_full  = (r_cnt == RESQ_CNT_W'(RESQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_mem[r_rp];
    assign c_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + RESQ_PTR_W'(1);
            end
            if (c_pop) begin
                r_rp <= r_rp + RESQ_PTR_W'(1);
            end
            if (i_push && !c_pop) begin
                r_cnt <= r_cnt + RESQ_CNT_W'(1);
            end else if (!i_push && c_pop) begin
                r_cnt <= r_cnt - RESQ_CNT_W'(1);
            end
        end
    end
endmodule

// ===== sv/key_scan_code_queue_pacer.sv =====
// Top level of the key scan code queue pacer: config registers and the
// front end, operation queue, back end and result queue. Depends on kscqp_pkg.
//
//   channel   handshake            payload
//   input     push / full          i_cmd, i_char_code, i_raw_code
//   result    empty / pop          o_key_action, o_key_code, o_dropped, o_queue_count
//   config    cfg_valid/cfg_ready  i_cfg_index, i_cfg_data
//
// One input beat enters per cycle while the two-entry operation queue has room.
// The back end retires one operation per cycle while the result queue has room;
// a press waits in a read state for the registered read of the code store RAM.
// Each result enters the result queue and reaches the ports once earlier ones pop.
// Reset clears pointers and pacing counters and loads the default config; the code store is not cleared.
// full rises when the operation queue holds two beats, which happens when the
// result queue is full or a press read is in flight.
module key_scan_code_queue_pacer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_raw_code,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_key_action,
    output logic [7:0] o_key_code,
    output logic       o_dropped,
    output logic [3:0] o_queue_count,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data
);
    import kscqp_pkg::*;

    t_cfg    r_cfg;
    t_op     c_front_op, c_back_op;
    logic    c_op_push, c_opq_full, c_op_valid, c_op_pop;
    logic    c_res_push, c_res_full;
    t_result c_back_res, c_out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attached <= RST_ATTACHED;
            r_cfg.hold     <= RST_HOLD;
            r_cfg.gap      <= RST_GAP;
        end else if (cfg_valid) begin
            unique case (i_cfg_index)
                REG_ATTACHED: r_cfg.attached <= i_cfg_data[0];
                REG_HOLD:     r_cfg.hold     <= i_cfg_data;
                REG_GAP:      r_cfg.gap      <= i_cfg_data;
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    kscqp_front u_front (
        .i_push      (push),
        .i_opq_full  (c_opq_full),
        .i_cmd       (i_cmd),
        .i_char_code (i_char_code),
        .i_raw_code  (i_raw_code),
        .i_cfg       (r_cfg),
        .o_full      (full),
        .o_op_push   (c_op_push),
        .o_op        (c_front_op)
    );

    kscqp_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_op_push),
        .i_op    (c_front_op),
        .o_full  (c_opq_full),
        .i_pop   (c_op_pop),
        .o_valid (c_op_valid),
        .o_op    (c_back_op)
    );

    kscqp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_op_valid (c_op_valid),
        .i_op       (c_back_op),
        .o_op_pop   (c_op_pop),
        .i_res_full (c_res_full),
        .o_res_push (c_res_push),
        .o_res      (c_back_res)
    );

    kscqp_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_res_push),
        .i_res   (c_back_res),
        .o_full  (c_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (c_out_res)
    );

    assign o_key_action  = c_out_res.action;
    assign o_key_code    = c_out_res.code;
    assign o_dropped     = c_out_res.dropped;
    assign o_queue_count = c_out_res.count;
endmodule

// ===== sv/kscqp_checker.sv =====
// Port-level checks on the result channel of the key scan code queue pacer.
// Depends on kscqp_pkg; bound to key_scan_code_queue_pacer below.
module kscqp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_key_action,
    input logic [7:0] o_key_code,
    input logic       o_dropped
);
    import kscqp_pkg::*;

    // first beat boundary out of reset: nothing may be waiting yet
    a_empty_after_reset: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> empty)
        else $error("result waiting right after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_key_action) && $stable(o_key_code))
        else $error("waiting result changed before pop");

    a_code_only_on_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_key_action != ACT_PRESS |-> o_key_code == 8'h00)
        else $error("key code without a press");

    a_drop_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_dropped |-> o_key_action == ACT_NONE)
        else $error("dropped item carries a key action");
endmodule

bind key_scan_code_queue_pacer kscqp_checker u_kscqp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_key_action (o_key_action),
    .o_key_code   (o_key_code),
    .o_dropped    (o_dropped)
);
